@@ rtl/bhm_pkg.sv @@
// Package for the bucketed hash map: field widths, request and status codes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package bhm_pkg;

    localparam int KEY_W     = 16;
    localparam int VAL_W     = 18;
    localparam int ST_W      = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_SET    = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_KEY_ZERO = 2'd2;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV1  = 6'b000100,
        S_DIV2  = 6'b001000,
        S_READ  = 6'b010000,
        S_EVAL  = 6'b100000
    } bhm_state_t;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic div1;
        logic div2;
        logic rd;
        logic commit;
    } bhm_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } bhm_stat_t;

endpackage

@@ rtl/bucketed_hash_map.sv @@
// Top level of the bucketed hash map: a 4-way set-associative store from
// nonzero 16-bit keys to 18-bit handles. Depends on bhm_pkg, bhm_ctrl, bhm_dpath.
//
//  channel | dir | tdata (low bit up)           | tuser (low bit up)
//  s_      | in  | key[15:0], value[33:16], pad | req_type
//  m_      | out | data_out[17:0], pad          | found[0], status[2:1]
//
// Each request runs through the controller states from acceptance to the next
// acceptance: accept, the reciprocal multiply that forms key mod NUM_BUCKETS
// (quotient, then remainder), the bucket read from the key and handle RAMs, and
// evaluation and bucket write-back. The result sits in an output register,
// so the next item is accepted while it waits; evaluation holds while that
// register is full and not being taken. After reset a clearing pass empties
// every bucket of the key RAM, and s_tready stays low until it ends.
module bucketed_hash_map #(
    parameter int NUM_BUCKETS = 256,
    parameter int WAYS        = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bhm_pkg::S_TDATA_W-1:0] s_tdata,  // key[15:0], value[33:16], zero pad
    input  logic                          s_tuser,  // req_type: 0 lookup, 1 set
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bhm_pkg::M_TDATA_W-1:0] m_tdata,  // data_out[17:0], zero pad
    output logic [bhm_pkg::M_TUSER_W-1:0] m_tuser   // found[0], status[2:1]
);
    import bhm_pkg::*;

    bhm_cmd_t  cmd;
    bhm_stat_t stat;

    // The controller sequences each request through the datapath stages.
    bhm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the RAMs, the bucket index unit and the output register.
    bhm_dpath #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/bhm_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module bhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ rtl/bhm_ctrl.sv @@
// Controller state machine for the bucketed hash map.
// Depends on bhm_pkg.
module bhm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bhm_pkg::bhm_stat_t stat,
    output bhm_pkg::bhm_cmd_t  cmd
);
    import bhm_pkg::*;

    bhm_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV1;
                end
            end
            S_DIV1: begin
                cmd.div1   = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2: begin
                cmd.div2   = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (!stat.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/bhm_dpath.sv @@
// Datapath for the bucketed hash map: request registers, bucket index unit,
// key and handle RAMs, bucket update logic and output register.
// Depends on bhm_pkg and bhm_ram.
module bhm_dpath #(
    parameter int NUM_BUCKETS = 256,
    parameter int WAYS        = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bhm_pkg::bhm_cmd_t                cmd,
    output bhm_pkg::bhm_stat_t               stat,
    input  logic [bhm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bhm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [bhm_pkg::M_TUSER_W-1:0]    m_tuser
);
    import bhm_pkg::*;

    localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW  = $clog2(WAYS + 1);
    localparam logic [63:0] RECIP_W =
        ((64'd1 << 32) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
    localparam logic [31:0] RECIP = RECIP_W[31:0];

    logic             req_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [KEY_W-1:0] quo_reg;
    logic [BW-1:0]    bucket_reg;
    logic [BW-1:0]    clr_cnt_reg;

    logic             out_valid_reg;
    logic             found_reg;
    logic [VAL_W-1:0] data_reg;
    logic [ST_W-1:0]  status_reg;

    logic [47:0] quo_prod;
    logic [32:0] quo_mul;
    logic [32:0] rem;

    logic [WAYS*KEY_W-1:0] key_row, key_wrow;
    logic [WAYS*VAL_W-1:0] hdl_row, hdl_wrow;
    logic [BW-1:0]         ram_addr;
    logic                  key_we, hdl_we;

    logic [KEY_W-1:0] keys [WAYS+1];
    logic [VAL_W-1:0] hdls [WAYS+1];
    logic             hit, stop;
    logic [WIW-1:0]   hit_idx;
    logic [CW-1:0]    used;
    logic [VAL_W-1:0] hit_hdl;
    logic             key_zero;
    logic             nxt_found;
    logic [VAL_W-1:0] nxt_data;
    logic [ST_W-1:0]  nxt_status;
    logic             do_key_wr, do_hdl_wr;

    // Bucket index: key mod NUM_BUCKETS by an exact reciprocal multiply.
    assign quo_prod = 48'(key_reg) * 48'(RECIP);
    assign quo_mul  = 33'(quo_reg) * 33'(NUM_BUCKETS);
    assign rem      = 33'(key_reg) - quo_mul;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_tuser;
            key_reg <= s_tdata[KEY_W-1:0];
            val_reg <= s_tdata[KEY_W +: VAL_W];
        end
        if (cmd.div1) begin
            quo_reg <= quo_prod[47:32];
        end
        if (cmd.div2) begin
            bucket_reg <= rem[BW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_cnt_reg <= clr_cnt_reg + BW'(1);
        end
    end

    assign stat.clr_last = (clr_cnt_reg == BW'(NUM_BUCKETS - 1));
    assign stat.out_busy = out_valid_reg && !m_tready;

    // Bucket evaluation. Ways are kept packed at the low end of a bucket.
    always_comb begin
        hit     = 1'b0;
        stop    = 1'b0;
        hit_idx = '0;
        used    = '0;
        hit_hdl = '0;
        for (int w = 0; w < WAYS; w++) begin
            keys[w] = key_row[w*KEY_W +: KEY_W];
            hdls[w] = hdl_row[w*VAL_W +: VAL_W];
        end
        keys[WAYS] = '0;
        hdls[WAYS] = hdl_row[(WAYS-1)*VAL_W +: VAL_W];
        for (int w = 0; w < WAYS; w++) begin
            if (!stop && keys[w] != '0) begin
                used = used + CW'(1);
            end else begin
                stop = 1'b1;
            end
            if (!hit && keys[w] == key_reg) begin
                hit     = 1'b1;
                hit_idx = WIW'(w);
                hit_hdl = hdls[w];
            end
        end

        key_zero   = (key_reg == '0);
        nxt_found  = 1'b0;
        nxt_data   = '0;
        nxt_status = ST_OK;
        do_key_wr  = 1'b0;
        do_hdl_wr  = 1'b0;
        key_wrow   = key_row;
        hdl_wrow   = hdl_row;

        if (key_zero) begin
            nxt_status = ST_KEY_ZERO;
        end else if (req_reg == REQ_LOOKUP) begin
            nxt_found = hit;
            nxt_data  = hit ? hit_hdl : '0;
        end else if (val_reg == '0) begin
            // Delete: ways from the hit onward move up by one.
            nxt_found = hit;
            do_key_wr = hit;
            do_hdl_wr = hit;
            for (int w = 0; w < WAYS; w++) begin
                if (WIW'(w) >= hit_idx) begin
                    key_wrow[w*KEY_W +: KEY_W] = keys[w+1];
                    hdl_wrow[w*VAL_W +: VAL_W] = hdls[w+1];
                end
            end
        end else if (hit) begin
            nxt_found = 1'b1;
            do_hdl_wr = 1'b1;
            for (int w = 0; w < WAYS; w++) begin
                if (WIW'(w) == hit_idx) begin
                    hdl_wrow[w*VAL_W +: VAL_W] = val_reg;
                end
            end
        end else if (used >= CW'(WAYS)) begin
            nxt_status = ST_FULL;
        end else begin
            do_key_wr = 1'b1;
            do_hdl_wr = 1'b1;
            for (int w = 0; w < WAYS; w++) begin
                if (CW'(w) == used) begin
                    key_wrow[w*KEY_W +: KEY_W] = key_reg;
                    hdl_wrow[w*VAL_W +: VAL_W] = val_reg;
                end
            end
        end
    end

    assign ram_addr = cmd.clr_en ? clr_cnt_reg : bucket_reg;
    assign key_we   = cmd.clr_en || (cmd.commit && do_key_wr);
    assign hdl_we   = cmd.commit && do_hdl_wr;

    bhm_ram #(
        .WIDTH (WAYS*KEY_W),
        .DEPTH (NUM_BUCKETS)
    ) u_key_ram (
        .clk   (aclk),
        .we    (key_we),
        .re    (cmd.rd),
        .addr  (ram_addr),
        .wdata (cmd.clr_en ? '0 : key_wrow),
        .rdata (key_row)
    );

    bhm_ram #(
        .WIDTH (WAYS*VAL_W),
        .DEPTH (NUM_BUCKETS)
    ) u_hdl_ram (
        .clk   (aclk),
        .we    (hdl_we),
        .re    (cmd.rd),
        .addr  (ram_addr),
        .wdata (hdl_wrow),
        .rdata (hdl_row)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            found_reg  <= nxt_found;
            data_reg   <= nxt_data;
            status_reg <= nxt_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-VAL_W){1'b0}}, data_reg};
    assign m_tuser  = {status_reg, found_reg};

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(out_valid_reg && !m_tready))
        else $error("result loaded while previous result pending");

    // Handle data only accompanies a hit.
    a_data_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && data_reg != '0) |-> found_reg)
        else $error("nonzero data without found");

    // Rejected and dropped requests never report a hit.
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (status_reg == ST_KEY_ZERO || status_reg == ST_FULL))
        |-> (!found_reg && data_reg == '0))
        else $error("rejected request reports found or data");

    // No request work is issued during the clearing pass.
    a_clear_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_en |-> !(cmd.load || cmd.rd || cmd.commit))
        else $error("request activity during clear");

endmodule

@@ sim/bucketed_hash_map_tb.sv @@
// Self-checking testbench for the bucketed hash map: a directed table, then random
// requests clustered on a few buckets, checked against a predictor of the bucket store.
// Depends on bhm_pkg and bucketed_hash_map.
`timescale 1ns / 1ps

module bucketed_hash_map_tb;
    import bhm_pkg::*;

    localparam int NUM_BUCKETS  = 256;
    localparam int WAYS         = 4;
    localparam int SLOTS        = NUM_BUCKETS * WAYS;
    localparam int RANDOM_ITEMS = 1380;
    localparam int DRAIN_CYCLES = 20;

    // One result item as the predictor sees it.
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] data_out;
        logic [ST_W-1:0]  status;
    } map_result_t;

    // One row of the directed table. Rows with hand_checked set carry the
    // expected result typed in; the others are checked against the predictor.
    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             hand_checked;
        map_result_t      want;
    } directed_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = REQ_LOOKUP;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // Predictor copy of the two stores. Only handles of occupied ways are ever read.
    logic [KEY_W-1:0] shadow_keys [SLOTS];
    logic [VAL_W-1:0] shadow_handles [SLOTS];

    map_result_t pending_results [$];
    int unsigned mismatches = 0;

    // Keys of the random part are built from a few hot buckets and a few high
    // bytes, so buckets fill up, overflow and get keys deleted from every way.
    logic [7:0] hot_buckets [7] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd77, 8'd128, 8'd255};
    logic [7:0] hot_highs [6]   = '{8'h00, 8'h01, 8'h55, 8'hAA, 8'h80, 8'hFF};

    // Directed table. Bucket 1 is filled with keys 1, 257, 513 and 769, then
    // overflowed, then has keys deleted from the middle, the front and the back.
    directed_row_t directed_plan [24] = '{
        '{REQ_LOOKUP, 16'd0,     18'd0,      1'b1, '{1'b0, 18'd0,      ST_KEY_ZERO}},
        '{REQ_SET,    16'd0,     18'h3FFFF,  1'b1, '{1'b0, 18'd0,      ST_KEY_ZERO}},
        '{REQ_SET,    16'd0,     18'd0,      1'b1, '{1'b0, 18'd0,      ST_KEY_ZERO}},
        '{REQ_LOOKUP, 16'd1,     18'd0,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd1,     18'h3FFFF,  1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_LOOKUP, 16'd1,     18'h15555,  1'b1, '{1'b1, 18'h3FFFF,  ST_OK}},
        '{REQ_SET,    16'hFFFF,  18'd1,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_LOOKUP, 16'hFFFF,  18'd0,      1'b1, '{1'b1, 18'd1,      ST_OK}},
        '{REQ_SET,    16'd1,     18'h2AAAA,  1'b1, '{1'b1, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd257,   18'd2,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd513,   18'd3,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd769,   18'd4,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd1025,  18'd5,      1'b1, '{1'b0, 18'd0,      ST_FULL}},
        '{REQ_LOOKUP, 16'd1025,  18'd0,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd257,   18'd0,      1'b1, '{1'b1, 18'd0,      ST_OK}},
        '{REQ_LOOKUP, 16'd513,   18'd0,      1'b0, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_LOOKUP, 16'd769,   18'd0,      1'b0, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd1025,  18'd6,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd2,     18'd0,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd1,     18'd0,      1'b1, '{1'b1, 18'd0,      ST_OK}},
        '{REQ_LOOKUP, 16'd1,     18'd0,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'd1025,  18'd0,      1'b0, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_LOOKUP, 16'd1025,  18'd0,      1'b1, '{1'b0, 18'd0,      ST_OK}},
        '{REQ_SET,    16'hFFFF,  18'd0,      1'b1, '{1'b1, 18'd0,      ST_OK}}
    };

    bucketed_hash_map #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .WAYS       (WAYS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Applies one request to the shadow stores and returns the result it should give.
    // The occupied ways of a bucket stay packed at the low end, so the scan stops
    // at the first empty way.
    function automatic map_result_t apply_request(input logic req_type,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] value);
        map_result_t res;
        int base;
        int used;
        int hit_way;
        bit hit;
        res = '{1'b0, '0, ST_OK};
        hit = 1'b0;
        hit_way = 0;
        if (key == '0) begin
            res.status = ST_KEY_ZERO;
            return res;
        end
        base = (int'(key) % NUM_BUCKETS) * WAYS;
        used = WAYS;
        for (int w = 0; w < WAYS; w++) begin
            if (shadow_keys[base + w] == '0) begin
                used = w;
                break;
            end
            if (!hit && shadow_keys[base + w] == key) begin
                hit = 1'b1;
                hit_way = w;
            end
        end
        res.found = hit;
        if (req_type == REQ_LOOKUP) begin
            if (hit)
                res.data_out = shadow_handles[base + hit_way];
        end else if (value == '0) begin
            // Delete: later ways move up by one, the last occupied way empties.
            if (hit) begin
                for (int w = hit_way + 1; w < used; w++) begin
                    shadow_keys[base + w - 1]    = shadow_keys[base + w];
                    shadow_handles[base + w - 1] = shadow_handles[base + w];
                end
                shadow_keys[base + used - 1]    = '0;
                shadow_handles[base + used - 1] = '0;
            end
        end else if (hit) begin
            shadow_handles[base + hit_way] = value;
        end else if (used >= WAYS) begin
            res.status = ST_FULL;
        end else begin
            shadow_keys[base + used]    = key;
            shadow_handles[base + used] = value;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Presents one item from the next falling edge on and holds it until the
    // block takes it. The predictor runs at the accepting edge, so the queue of
    // expected results keeps the order in which the block saw the items.
    task automatic send_request(input logic req_type, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value, input bit hand_checked,
                                input map_result_t hand_want);
        map_result_t predicted;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= req_type;
        s_tdata  <= {{(S_TDATA_W - KEY_W - VAL_W){1'b0}}, value, key};
        do
            @(posedge aclk);
        while (!s_tready);
        predicted = apply_request(req_type, key, value);
        pending_results.push_back(hand_checked ? hand_want : predicted);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Stops sending and waits until every result in flight has come back.
    task automatic wait_drained();
        hold_off(0);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Random request: mostly sets, deletes and lookups on the hot buckets, plus
    // some keys from the whole range and a few key-zero requests.
    task automatic send_random_request();
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        int               pick;
        pick  = $urandom_range(0, 99);
        key   = {hot_highs[$urandom_range(0, 5)], hot_buckets[$urandom_range(0, 6)]};
        value = VAL_W'($urandom_range(1, 262143));
        if ($urandom_range(0, 9) == 0)
            key = KEY_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 19) == 0)
            value = ($urandom_range(0, 1) != 0) ? 18'h3FFFF : 18'd1;
        if (pick < 40) begin
            req_type = REQ_SET;
        end else if (pick < 58) begin
            req_type = REQ_SET;
            value    = '0;
        end else if (pick < 96) begin
            req_type = REQ_LOOKUP;
        end else begin
            req_type = logic'($urandom_range(0, 1));
            key      = '0;
            if ($urandom_range(0, 1) != 0)
                value = '0;
        end
        send_request(req_type, key, value, 1'b0, '0);
    endtask

    // The receiver switches among three stall patterns: always ready, ready
    // about half the time, or ready only now and then.
    int unsigned rx_cycle = 0;
    int unsigned rx_mode  = 0;
    always @(negedge aclk) begin
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 2);
        rx_cycle++;
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 1) != 0);
            end
            default: begin
                m_tready <= ($urandom_range(0, 4) == 0);
            end
        endcase
    end

    // Result checker: every accepted result item is compared with the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result item", {m_tuser, m_tdata}, 0);
            end else begin
                map_result_t want;
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.found)
                    report_mismatch("found", m_tuser[0], want.found);
                if (m_tdata[VAL_W-1:0] !== want.data_out)
                    report_mismatch("data_out", m_tdata[VAL_W-1:0], want.data_out);
                if (m_tuser[2:1] !== want.status)
                    report_mismatch("status", m_tuser[2:1], want.status);
            end
        end
    end

    // Main sequence.
    initial begin
        int sent;
        int burst_left;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_keys[i]    = '0;
            shadow_handles[i] = '0;
        end

        // Reset is held at first, released on a falling edge. The block then runs
        // its clearing pass with s_tready low; the sender simply waits on it.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, back to back so the same bucket is hit on consecutive items.
        foreach (directed_plan[i])
            send_request(directed_plan[i].req_type, directed_plan[i].key,
                         directed_plan[i].value, directed_plan[i].hand_checked,
                         directed_plan[i].want);
        wait_drained();

        // Random part: bursts of random length with random gaps, some gaps zero
        // so long runs without idling happen too. Halfway through, the sender
        // stops until every result has come back.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst_left = $urandom_range(1, 16);
            while (burst_left > 0 && sent < RANDOM_ITEMS) begin
                send_random_request();
                sent++;
                burst_left--;
                if (sent == RANDOM_ITEMS / 2)
                    wait_drained();
            end
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(0, 6));
        end

        // Let the last results come out, then a few more cycles for stray items.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS bucketed_hash_map");
        else
            $display("FAIL bucketed_hash_map");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (clearing pass, every item
    // waiting out sender gaps, the request states and long receiver stalls).
    initial begin
        #5_000_000;
        $display("FAIL bucketed_hash_map");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bhm_pkg.sv
rtl/bhm_ram.sv
rtl/bhm_ctrl.sv
rtl/bhm_dpath.sv
rtl/bucketed_hash_map.sv
sim/bucketed_hash_map_tb.sv
